>>> src/assert_macros.svh
// assertion macros included by the execute unit top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> src/bceu_pkg.sv
// types, constants and helpers of the basic computer execute unit
package bceu_pkg;

   localparam int ADDR_W    = 12;
   localparam int WORD_W    = 16;
   localparam int CHAR_W    = 8;
   localparam int ADDR_SPAN = 1 << ADDR_W;
   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int MOD_STEPS = ADDR_SPAN / MEM_WORDS;

   // register reference bit positions, highest priority first
   localparam int RR_CLA = 11;
   localparam int RR_CLE = 10;
   localparam int RR_CMA = 9;
   localparam int RR_CME = 8;
   localparam int RR_CIR = 7;
   localparam int RR_CIL = 6;
   localparam int RR_INC = 5;
   localparam int RR_SPA = 4;
   localparam int RR_SNA = 3;
   localparam int RR_SZA = 2;
   localparam int RR_SZE = 1;
   localparam int RR_HLT = 0;

   // i/o bit positions
   localparam int IO_INP = 11;
   localparam int IO_OUT = 10;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_SETPC = 2'd2,
      KIND_EXEC  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_AND = 3'd0,
      OP_ADD = 3'd1,
      OP_LDA = 3'd2,
      OP_STA = 3'd3,
      OP_BUN = 3'd4,
      OP_BSA = 3'd5,
      OP_ISZ = 3'd6,
      OP_RIO = 3'd7
   } op_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] data_word;
      logic [CHAR_W-1:0] in_char;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc_value;
      logic              extend_value;
      logic [ADDR_W-1:0] pc_value;
      logic              running;
      logic [WORD_W-1:0] read_data;
      logic              out_valid;
      logic [CHAR_W-1:0] out_high;
      logic [CHAR_W-1:0] out_low;
   } rsp_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc;
      logic              ext;
      logic [ADDR_W-1:0] pc;
      logic              run;
   } arch_type;

   typedef struct packed {
      arch_type          arch;
      logic              mem_we;
      logic [WORD_W-1:0] mem_wdata;
      rsp_word_type      rsp;
   } exec_out_type;

   // address folded into the memory by repeated subtraction
   function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
      logic [ADDR_W:0] v;
      v = {1'b0, a};
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (v >= (ADDR_W+1)'(MEM_WORDS)) begin
            v = v - (ADDR_W+1)'(MEM_WORDS);
         end
      end
      return v[MEM_AW-1:0];
   endfunction

endpackage

>>> src/bceu_if.sv
// valid/ready channel interfaces for request and response words
interface bceu_req_if;
   import bceu_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bceu_rsp_if;
   import bceu_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/basic_computer_execute_unit_top.sv
// Execute unit of a 16-bit accumulator machine with its main memory. A request word is
// taken every cycle while the response side keeps up: the memory is read at the
// accepting edge, and the word then executes and writes back at the edge on which its
// response word is registered, so a sustained rate of one word per clock is reached.
// A write-back landing on the same edge as the next word's read is forwarded around the
// memory's single read port. Memory contents are undefined until written; there is no
// clearing pass after reset, so requests are taken from the first cycle.
`include "assert_macros.svh"

module basic_computer_execute_unit_top (
   input logic       clock,
   input logic       reset,
   bceu_req_if.sink   req_chan,
   bceu_rsp_if.source rsp_chan
);
   import bceu_pkg::*;

   logic [WORD_W-1:0] mem_ff [MEM_WORDS];
   logic [WORD_W-1:0] ram_q_ff;

   logic              s2_valid_ff, s2_valid_in;
   req_word_type      s2_item_ff;
   logic [MEM_AW-1:0] s2_idx_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0] fwd_data_ff;
   arch_type          arch_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff;

   logic              req_take;
   logic              s2_fire;
   logic [MEM_AW-1:0] req_idx;
   logic [WORD_W-1:0] mem_word;
   exec_out_type      exec_res;

   assign s2_fire  = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s2_valid_ff || s2_fire;
   assign req_take = req_chan.valid && req_chan.ready;

   // execute words carry their operand address in the low bits
   assign req_idx = mem_index(req_chan.payload.kind[1] ?
                              req_chan.payload.data_word[ADDR_W-1:0] :
                              req_chan.payload.address);

   assign mem_word = fwd_hit_ff ? fwd_data_ff : ram_q_ff;

   bceu_exec u_exec (
      .item     (s2_item_ff),
      .cur      (arch_ff),
      .mem_word (mem_word),
      .res      (exec_res)
   );

   // read-before-write memory with a registered read port
   always_ff @(posedge clock) begin
      if (s2_fire && exec_res.mem_we) begin
         mem_ff[s2_idx_ff] <= exec_res.mem_wdata;
      end
      if (req_take) begin
         ram_q_ff    <= mem_ff[req_idx];
         s2_item_ff  <= req_chan.payload;
         s2_idx_ff   <= req_idx;
         fwd_data_ff <= exec_res.mem_wdata;
      end
      if (s2_fire) begin
         rsp_word_ff <= exec_res.rsp;
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      fwd_hit_in   = fwd_hit_ff;
      if (s2_fire) s2_valid_in = 1'b0;
      if (req_take) begin
         s2_valid_in = 1'b1;
         fwd_hit_in  = s2_fire && exec_res.mem_we && (s2_idx_ff == req_idx);
      end
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (s2_fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         arch_ff      <= '0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         if (s2_fire) begin
            arch_ff <= exec_res.arch;
         end
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   `ASSERT_HOLDS(a_fire_gives_rsp, clock, reset, s2_fire |=> rsp_valid_ff)
   `ASSERT_HOLDS(a_fwd_on_same_edge, clock, reset,
      (req_take && s2_fire && exec_res.mem_we && (s2_idx_ff == req_idx)) |=> fwd_hit_ff)
   `ASSERT_HOLDS(a_halted_exec_keeps_pc, clock, reset,
      (s2_fire && (s2_item_ff.kind == KIND_EXEC) && !arch_ff.run) |=>
         (arch_ff == $past(arch_ff)))
   `ASSERT_NEVER(a_out_with_read, clock, reset,
      rsp_valid_ff && rsp_word_ff.out_valid && (rsp_word_ff.read_data != '0))

endmodule

>>> src/bceu_exec.sv
// instruction execute logic: next machine state, memory write-back and response word
module bceu_exec (
   input  bceu_pkg::req_word_type item,
   input  bceu_pkg::arch_type     cur,
   input  logic [15:0]            mem_word,
   output bceu_pkg::exec_out_type res
);
   import bceu_pkg::*;

   logic [ADDR_W-1:0] pc_inc;
   logic [ADDR_W-1:0] pc_skip;
   logic [WORD_W:0]   sum;
   logic [WORD_W:0]   ea_inc;
   logic [WORD_W-1:0] isz_word;
   logic [ADDR_W-1:0] ea;
   logic [WORD_W-1:0] w;

   assign w        = item.data_word;
   assign ea       = w[ADDR_W-1:0];
   assign pc_inc   = cur.pc + 12'd1;
   assign pc_skip  = cur.pc + 12'd2;
   assign sum      = {1'b0, cur.acc} + {1'b0, mem_word};
   assign ea_inc   = {cur.ext, cur.acc} + 17'd1;
   assign isz_word = mem_word + 16'd1;

   always_comb begin
      res.arch      = cur;
      res.mem_we    = 1'b0;
      res.mem_wdata = w;
      res.rsp       = '0;
      unique case (kind_type'(item.kind))
         KIND_WRITE: begin
            res.mem_we = 1'b1;
         end
         KIND_READ: begin
            res.rsp.read_data = mem_word;
         end
         KIND_SETPC: begin
            res.arch.pc  = item.address;
            res.arch.run = 1'b1;
         end
         KIND_EXEC: begin
            if (cur.run) begin
               res.arch.pc = pc_inc;
               unique case (op_type'(w[14:12]))
                  OP_AND: res.arch.acc = cur.acc & mem_word;
                  OP_ADD: begin
                     res.arch.acc = sum[WORD_W-1:0];
                     res.arch.ext = sum[WORD_W];
                  end
                  OP_LDA: res.arch.acc = mem_word;
                  OP_STA: begin
                     res.mem_we    = 1'b1;
                     res.mem_wdata = cur.acc;
                  end
                  OP_BUN: res.arch.pc = ea;
                  OP_BSA: begin
                     res.mem_we    = 1'b1;
                     res.mem_wdata = {w[15:13], 1'b0, pc_inc};
                     res.arch.pc   = ea + 12'd1;
                  end
                  OP_ISZ: begin
                     res.mem_we    = 1'b1;
                     res.mem_wdata = isz_word;
                     if (isz_word == '0) begin
                        res.arch.pc = pc_skip;
                     end
                  end
                  OP_RIO: begin
                     if (!w[15]) begin
                        priority if (w[RR_CLA]) res.arch.acc = '0;
                        else if (w[RR_CLE]) res.arch.ext = 1'b0;
                        else if (w[RR_CMA]) res.arch.acc = ~cur.acc;
                        else if (w[RR_CME]) res.arch.ext = ~cur.ext;
                        else if (w[RR_CIR]) begin
                           res.arch.acc = {cur.ext, cur.acc[WORD_W-1:1]};
                           res.arch.ext = cur.acc[0];
                        end else if (w[RR_CIL]) begin
                           res.arch.acc = {cur.acc[WORD_W-2:0], cur.ext};
                           res.arch.ext = cur.acc[WORD_W-1];
                        end else if (w[RR_INC]) begin
                           res.arch.acc = ea_inc[WORD_W-1:0];
                           res.arch.ext = ea_inc[WORD_W];
                        end else if (w[RR_SPA]) begin
                           if (!cur.acc[WORD_W-1]) res.arch.pc = pc_skip;
                        end else if (w[RR_SNA]) begin
                           if (cur.acc[WORD_W-1]) res.arch.pc = pc_skip;
                        end else if (w[RR_SZA]) begin
                           if (cur.acc == '0) res.arch.pc = pc_skip;
                        end else if (w[RR_SZE]) begin
                           if (!cur.ext) res.arch.pc = pc_skip;
                        end else if (w[RR_HLT]) res.arch.run = 1'b0;
                        else begin
                           // no operation bit: only the pc advances
                           res.arch.run = cur.run;
                        end
                     end else if (w[IO_INP]) begin
                        res.arch.acc = {{(WORD_W-CHAR_W){1'b0}}, item.in_char};
                     end else if (w[IO_OUT]) begin
                        res.rsp.out_valid = 1'b1;
                        res.rsp.out_high  = cur.acc[WORD_W-1:CHAR_W];
                        res.rsp.out_low   = cur.acc[CHAR_W-1:0];
                     end
                  end
               endcase
            end
         end
      endcase
      res.rsp.acc_value    = res.arch.acc;
      res.rsp.extend_value = res.arch.ext;
      res.rsp.pc_value     = res.arch.pc;
      res.rsp.running      = res.arch.run;
   end

endmodule

>>> tb/bceu_exec_checker.sv
// checker for the execute unit: tracks machine state, predicts each response word and compares
module bceu_exec_checker (
   input  logic  clock,
   input  logic  reset,
   bceu_req_if   req_mon,
   bceu_rsp_if   rsp_mon,
   output int    fail_count,
   output int    owed_count
);
   import bceu_pkg::*;

   localparam int PRINT_CAP = 40;

   logic [WORD_W-1:0] mach_mem [MEM_WORDS];
   logic [WORD_W-1:0] mach_acc;
   logic              mach_ext;
   logic [ADDR_W-1:0] mach_pc;
   logic              mach_run;
   rsp_word_type      owed_words[$];
   rsp_word_type      want;

   initial begin
      fail_count = 0;
      owed_count = 0;
   end

   task automatic flag_error(input string what, input logic [15:0] got,
                             input logic [15:0] exp_val);
      if (fail_count < PRINT_CAP) begin
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, exp_val);
      end
      fail_count++;
   endtask

   task automatic compare_field(input string what, input logic [15:0] got,
                                input logic [15:0] exp_val);
      if (got !== exp_val) begin
         flag_error(what, got, exp_val);
      end
   endtask

   // applies one request word to the tracked machine and builds its response word
   task automatic run_request(input req_word_type w, output rsp_word_type r);
      logic [ADDR_W-1:0] ea;
      logic [ADDR_W-1:0] bits;
      logic [WORD_W-1:0] m;
      logic [WORD_W:0]   sum;
      logic              t;
      int                slot;
      r    = '0;
      ea   = w.data_word[ADDR_W-1:0];
      bits = w.data_word[ADDR_W-1:0];
      slot = int'(ea) % MEM_WORDS;
      case (w.kind)
         KIND_WRITE: mach_mem[int'(w.address) % MEM_WORDS] = w.data_word;
         KIND_READ:  r.read_data = mach_mem[int'(w.address) % MEM_WORDS];
         KIND_SETPC: begin
            mach_pc  = w.address;
            mach_run = 1'b1;
         end
         default: begin
            if (mach_run) begin
               mach_pc = mach_pc + 12'd1;
               case (w.data_word[14:12])
                  OP_AND: mach_acc = mach_acc & mach_mem[slot];
                  OP_ADD: begin
                     sum = {1'b0, mach_acc} + {1'b0, mach_mem[slot]};
                     {mach_ext, mach_acc} = sum;
                  end
                  OP_LDA: mach_acc = mach_mem[slot];
                  OP_STA: mach_mem[slot] = mach_acc;
                  OP_BUN: mach_pc = ea;
                  OP_BSA: begin
                     // return word keeps the top three instruction bits
                     mach_mem[slot] = {w.data_word[15:13], 1'b0, mach_pc};
                     mach_pc = ea + 12'd1;
                  end
                  OP_ISZ: begin
                     m = mach_mem[slot] + 16'd1;
                     mach_mem[slot] = m;
                     if (m == '0) begin
                        mach_pc = mach_pc + 12'd1;
                     end
                  end
                  default: begin
                     if (!w.data_word[15]) begin
                        // only the highest set bit acts
                        if (bits[RR_CLA]) begin
                           mach_acc = '0;
                        end else if (bits[RR_CLE]) begin
                           mach_ext = 1'b0;
                        end else if (bits[RR_CMA]) begin
                           mach_acc = ~mach_acc;
                        end else if (bits[RR_CME]) begin
                           mach_ext = ~mach_ext;
                        end else if (bits[RR_CIR]) begin
                           t = mach_acc[0];
                           mach_acc = {mach_ext, mach_acc[WORD_W-1:1]};
                           mach_ext = t;
                        end else if (bits[RR_CIL]) begin
                           t = mach_acc[WORD_W-1];
                           mach_acc = {mach_acc[WORD_W-2:0], mach_ext};
                           mach_ext = t;
                        end else if (bits[RR_INC]) begin
                           {mach_ext, mach_acc} = {mach_ext, mach_acc} + 17'd1;
                        end else if (bits[RR_SPA]) begin
                           if (!mach_acc[WORD_W-1]) mach_pc = mach_pc + 12'd1;
                        end else if (bits[RR_SNA]) begin
                           if (mach_acc[WORD_W-1]) mach_pc = mach_pc + 12'd1;
                        end else if (bits[RR_SZA]) begin
                           if (mach_acc == '0) mach_pc = mach_pc + 12'd1;
                        end else if (bits[RR_SZE]) begin
                           if (!mach_ext) mach_pc = mach_pc + 12'd1;
                        end else if (bits[RR_HLT]) begin
                           mach_run = 1'b0;
                        end
                     end else if (w.data_word[IO_INP]) begin
                        mach_acc = {8'h00, w.in_char};
                     end else if (w.data_word[IO_OUT]) begin
                        r.out_valid = 1'b1;
                        r.out_high  = mach_acc[15:8];
                        r.out_low   = mach_acc[7:0];
                     end
                  end
               endcase
            end
         end
      endcase
      r.acc_value    = mach_acc;
      r.extend_value = mach_ext;
      r.pc_value     = mach_pc;
      r.running      = mach_run;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mach_acc = '0;
         mach_ext = 1'b0;
         mach_pc  = '0;
         mach_run = 1'b0;
         owed_words.delete();
      end else begin
         // responses first: a word never answers a request taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_words.size() == 0) begin
               flag_error("response word with nothing owed", rsp_mon.payload.acc_value, '0);
            end else begin
               want = owed_words.pop_front();
               compare_field("acc_value", rsp_mon.payload.acc_value, want.acc_value);
               compare_field("extend_value", 16'(rsp_mon.payload.extend_value),
                             16'(want.extend_value));
               compare_field("pc_value", 16'(rsp_mon.payload.pc_value), 16'(want.pc_value));
               compare_field("running", 16'(rsp_mon.payload.running), 16'(want.running));
               compare_field("read_data", rsp_mon.payload.read_data, want.read_data);
               compare_field("out_valid", 16'(rsp_mon.payload.out_valid),
                             16'(want.out_valid));
               compare_field("out_high", 16'(rsp_mon.payload.out_high), 16'(want.out_high));
               compare_field("out_low", 16'(rsp_mon.payload.out_low), 16'(want.out_low));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            run_request(req_mon.payload, want);
            owed_words.push_back(want);
         end
      end
      owed_count <= owed_words.size();
   end

endmodule

>>> tb/tb_basic_computer_execute_unit_top.sv
// top of the execute unit testbench: clock, reset, request stimulus, response stalls and verdict
module tb_basic_computer_execute_unit_top;
   import bceu_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock;
   logic              reset;
   int                fail_count;
   int                owed_count;
   int                cycle_count;
   int                burst_left;
   int                items_sent;
   logic [ADDR_W-1:0] known_addrs[$];
   bit                known_map [ADDR_SPAN];
   logic [7:0]        ready_pattern = 8'hFF;
   logic [7:0]        stall_tick = '0;

   bceu_req_if req_bus ();
   bceu_rsp_if rsp_bus ();

   basic_computer_execute_unit_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   bceu_exec_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .owed_count (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls on a byte pattern that is redrawn whenever the low five tick bits are zero, sometimes all open
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[4:0] == 5'd0) begin
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      rsp_bus.ready <= ready_pattern[stall_tick[2:0]];
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("basic_computer_execute_unit_top verification failed");
      $finish;
   end

   function automatic logic [15:0] rr_word(input int bit_pos);
      return {1'b0, OP_RIO, 12'd1 << bit_pos};
   endfunction

   function automatic logic [15:0] io_word(input int bit_pos);
      return {1'b1, OP_RIO, 12'd1 << bit_pos};
   endfunction

   function automatic logic [ADDR_W-1:0] pick_known();
      return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
   endfunction

   function automatic logic [15:0] random_data();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // instruction word whose memory reads only touch words already written
   function automatic logic [15:0] random_instr();
      logic [2:0]        op;
      logic [ADDR_W-1:0] ea;
      logic              ind;
      int                k;
      op  = 3'($urandom_range(0, 7));
      ind = 1'($urandom);
      case (op)
         OP_AND, OP_ADD, OP_LDA, OP_ISZ: ea = pick_known();
         OP_STA, OP_BSA: ea = $urandom_range(0, 1) ? pick_known() : 12'($urandom);
         OP_BUN: ea = 12'($urandom);
         default: begin
            if (ind) begin
               ea = 12'($urandom);
            end else begin
               k = $urandom_range(0, 12);
               if (k == 12) begin
                  ea = '0;
               end else begin
                  // lower bits random so the priority rule gets exercised
                  ea = (12'd1 << k) | (12'($urandom) & ((12'd1 << k) - 12'd1));
               end
            end
         end
      endcase
      return {ind, op, ea};
   endfunction

   task automatic send_word(input kind_type kind, input logic [ADDR_W-1:0] addr,
                            input logic [15:0] data, input logic [7:0] ch);
      req_word_type w;
      w.kind      = kind;
      w.address   = addr;
      w.data_word = data;
      w.in_char   = ch;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= w;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      burst_left--;
      items_sent++;
      if (kind == KIND_WRITE && !known_map[addr]) begin
         known_map[addr] = 1'b1;
         known_addrs.push_back(addr);
      end
   endtask

   task automatic send_exec(input logic [15:0] instr);
      send_word(KIND_EXEC, 12'($urandom), instr, 8'($urandom));
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   initial begin
      int sel;
      int n;
      int next_drain;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      burst_left      = 0;
      items_sent      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_word(KIND_WRITE, 12'h000, 16'hFFFF, 8'h00);
      send_word(KIND_WRITE, 12'hFFF, 16'h0001, 8'hFF);
      send_word(KIND_WRITE, 12'h005, 16'hFFFF, 8'h00);
      send_word(KIND_READ, 12'hFFF, 16'h0000, 8'h00);
      send_word(KIND_SETPC, 12'hFFF, 16'h0000, 8'h00);
      send_exec({1'b0, OP_LDA, 12'h000});             // pc wraps past the top
      send_exec({1'b0, OP_ADD, 12'hFFF});             // carry into e
      send_exec({1'b0, OP_ISZ, 12'h005});             // wraps to zero and skips
      send_word(KIND_EXEC, 12'h000, io_word(IO_INP) | io_word(IO_OUT), 8'hFF);
      send_exec(io_word(IO_OUT));
      send_exec(rr_word(RR_CIL));
      send_exec(rr_word(RR_CIR));
      send_exec(rr_word(RR_CMA));
      send_exec(rr_word(RR_INC));
      send_exec(rr_word(RR_SPA) | rr_word(RR_SZA) | rr_word(RR_SZE));
      send_exec(rr_word(RR_SNA) | rr_word(RR_HLT));
      send_exec(rr_word(RR_CME));
      send_exec(rr_word(RR_SZE));
      send_exec({1'b0, OP_RIO, 12'hFFF});             // all bits set, clear acc wins
      send_exec(rr_word(RR_SZA));
      send_exec(rr_word(RR_CLE));
      send_exec({1'b1, OP_AND, 12'h000});
      send_exec({1'b0, OP_STA, 12'hABC});
      send_exec({1'b0, OP_BUN, 12'hFFF});
      send_exec({1'b1, OP_BSA, 12'h7FF});
      send_exec({1'b0, OP_RIO, 12'h000});             // no operation bit
      send_exec({1'b1, OP_RIO, 12'h000});
      send_exec(rr_word(RR_HLT));
      send_exec({1'b0, OP_LDA, 12'h000});             // ignored while halted
      wait_for_drain();

      // random part: mostly short programs after a pc load, about half of them ending in a halt
      items_sent = 0;
      next_drain = 300;
      while (items_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(KIND_WRITE,
                         $urandom_range(0, 1) ? 12'($urandom_range(0, 31)) : 12'($urandom),
                         random_data(), 8'($urandom));
            end
         end else if (sel < 18) begin
            repeat ($urandom_range(1, 4)) begin
               send_word(KIND_READ, pick_known(), 16'($urandom), 8'($urandom));
            end
         end else if (sel < 92) begin
            send_word(KIND_SETPC, 12'($urandom), 16'($urandom), 8'($urandom));
            n = $urandom_range(2, 40);
            repeat (n) send_exec(random_instr());
            if ($urandom_range(0, 1)) begin
               send_exec(rr_word(RR_HLT));
               if ($urandom_range(0, 3) == 0) send_exec(random_instr());
            end
         end else begin
            repeat ($urandom_range(1, 4)) send_exec(random_instr());
         end
         if (items_sent >= next_drain) begin
            wait_for_drain();
            next_drain = items_sent + $urandom_range(200, 400);
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("basic_computer_execute_unit_top verification clean");
      end else begin
         $display("basic_computer_execute_unit_top verification failed");
      end
      $finish;
   end

endmodule
